[design/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the frame receiver: event codes, register
// indexes, header phase and the item structs passed between stages.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int STAT_WIDTH_DEF = 32;
    localparam int OUT_STAT_W     = 32;
    localparam int LEN_W          = 16;
    localparam int TICK_W         = 24;
    localparam int CFG_DATA_W     = 24;
    localparam int DROP_W         = 17;

    localparam logic [2:0]        HDR_SIZE         = 3'd4;
    localparam logic [TICK_W-1:0] IDLE_MAX         = 24'hFF_FFFF;
    localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST  = 16'd255;
    localparam logic [TICK_W-1:0] IDLE_TIMEOUT_RST = 24'd50000;

    typedef enum logic [2:0] {
        EV_NONE          = 3'd0,
        EV_PAYLOAD_BYTE  = 3'd1,
        EV_EMPTY_FRAME   = 3'd2,
        EV_FRAMING_ERROR = 3'd3,
        EV_IDLE_ABORT    = 3'd4
    } event_kind_t;

    typedef enum logic {
        REG_MAX_PAYLOAD_LEN = 1'b0,
        REG_IDLE_TIMEOUT    = 1'b1
    } reg_index_t;

    typedef enum logic {
        PH_HEADER  = 1'b0,
        PH_PAYLOAD = 1'b1
    } phase_t;

    typedef enum logic {
        FUNC_BYTE = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        event_kind_t            event_kind;
        logic [7:0]             payload_byte;
        logic                   frame_last;
        logic [15:0]            frame_ctr;
        logic                   ctr_gap;
        logic [OUT_STAT_W-1:0]  framing_error_count;
        logic [OUT_STAT_W-1:0]  ctr_error_count;
        logic [OUT_STAT_W-1:0]  idle_timeout_count;
        logic [OUT_STAT_W-1:0]  dropped_byte_count;
        logic [OUT_STAT_W-1:0]  frame_count;
    } result_t;

endpackage

[design/sfr_in_reg.sv]
// ----------------------------------------------------------------------------
// sfr_in_reg
// Input register of the receiver: captures one item from the slave stream
// and holds it until the deframer consumes it.
// ----------------------------------------------------------------------------
module sfr_in_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    output logic              s_ready,
    input  sfr_pkg::in_item_t s_item,
    input  logic              advance,
    output logic              item_valid,
    output sfr_pkg::in_item_t item
);

    logic              valid_reg;
    sfr_pkg::in_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_valid && s_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

[design/sfr_deframer.sv]
// ----------------------------------------------------------------------------
// sfr_deframer
// Header parser, payload tracker, idle timer and statistics. Updates all
// state and forms one result per consumed item combinationally.
// ----------------------------------------------------------------------------
module sfr_deframer
#(
    parameter int STAT_WIDTH = sfr_pkg::STAT_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_addr,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           fire,
    input  sfr_pkg::in_item_t              item,
    output sfr_pkg::result_t               result
);

    // configuration
    logic [sfr_pkg::LEN_W-1:0]  max_len_reg;
    logic [sfr_pkg::TICK_W-1:0] timeout_reg;

    // frame state
    sfr_pkg::phase_t            phase_reg, phase_next;
    logic [1:0]                 hdr_pos_reg, hdr_pos_next;
    logic [7:0]                 hdr_b0_reg, hdr_b1_reg, hdr_b2_reg;
    logic [sfr_pkg::LEN_W-1:0]  plen_reg, plen_next;
    logic [sfr_pkg::LEN_W-1:0]  pseen_reg, pseen_next;
    logic [15:0]                cur_ctr_reg, cur_ctr_next;
    logic                       cur_gap_reg, cur_gap_next;
    logic [15:0]                last_ctr_reg, last_ctr_next;
    logic                       ctr_seen_reg, ctr_seen_next;
    logic [sfr_pkg::TICK_W-1:0] idle_reg, idle_next;

    // statistics
    logic [STAT_WIDTH-1:0] fe_cnt_reg, fe_cnt_next;
    logic [STAT_WIDTH-1:0] ctre_cnt_reg, ctre_cnt_next;
    logic [STAT_WIDTH-1:0] idle_cnt_reg, idle_cnt_next;
    logic [STAT_WIDTH-1:0] drop_cnt_reg, drop_cnt_next;
    logic [STAT_WIDTH-1:0] frame_cnt_reg, frame_cnt_next;

    sfr_pkg::event_kind_t       kind;
    logic [7:0]                 pbyte;
    logic                       last_flag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= sfr_pkg::MAX_PAYLOAD_RST;
            timeout_reg <= sfr_pkg::IDLE_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (sfr_pkg::reg_index_t'(cfg_addr))
                sfr_pkg::REG_MAX_PAYLOAD_LEN: max_len_reg <= cfg_wdata[sfr_pkg::LEN_W-1:0];
                sfr_pkg::REG_IDLE_TIMEOUT:    timeout_reg <= cfg_wdata;
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        logic [sfr_pkg::LEN_W-1:0] hdr_len;
        logic [15:0]               hdr_ctr;
        logic [sfr_pkg::LEN_W-1:0] seen_inc;
        logic                      gap;
        logic [sfr_pkg::DROP_W-1:0] got;

        hdr_len  = {hdr_b1_reg, hdr_b0_reg};
        hdr_ctr  = {item.rx_byte, hdr_b2_reg};
        seen_inc = pseen_reg + 1'b1;
        gap      = ctr_seen_reg && (hdr_ctr != last_ctr_reg + 16'd1);
        got      = (phase_reg == sfr_pkg::PH_HEADER)
                 ? sfr_pkg::DROP_W'(hdr_pos_reg)
                 : sfr_pkg::DROP_W'(sfr_pkg::HDR_SIZE) + sfr_pkg::DROP_W'(pseen_reg);

        phase_next     = phase_reg;
        hdr_pos_next   = hdr_pos_reg;
        plen_next      = plen_reg;
        pseen_next     = pseen_reg;
        cur_ctr_next   = cur_ctr_reg;
        cur_gap_next   = cur_gap_reg;
        last_ctr_next  = last_ctr_reg;
        ctr_seen_next  = ctr_seen_reg;
        idle_next      = idle_reg;
        fe_cnt_next    = fe_cnt_reg;
        ctre_cnt_next  = ctre_cnt_reg;
        idle_cnt_next  = idle_cnt_reg;
        drop_cnt_next  = drop_cnt_reg;
        frame_cnt_next = frame_cnt_reg;
        kind           = sfr_pkg::EV_NONE;
        pbyte          = 8'd0;
        last_flag      = 1'b0;

        if (item.func == sfr_pkg::FUNC_BYTE)
        begin
            idle_next = '0;
            if (phase_reg == sfr_pkg::PH_HEADER)
            begin
                if (hdr_pos_reg != 2'd3)
                begin
                    hdr_pos_next = hdr_pos_reg + 2'd1;
                end
                else
                begin
                    hdr_pos_next = 2'd0;
                    if (hdr_len > max_len_reg)
                    begin
                        // drop the whole header and resync
                        fe_cnt_next   = fe_cnt_reg + 1'b1;
                        drop_cnt_next = drop_cnt_reg + STAT_WIDTH'(sfr_pkg::HDR_SIZE);
                        plen_next     = '0;
                        pseen_next    = '0;
                        kind          = sfr_pkg::EV_FRAMING_ERROR;
                    end
                    else
                    begin
                        cur_gap_next  = gap;
                        if (gap)
                        begin
                            ctre_cnt_next = ctre_cnt_reg + 1'b1;
                        end
                        ctr_seen_next = 1'b1;
                        last_ctr_next = hdr_ctr;
                        cur_ctr_next  = hdr_ctr;
                        pseen_next    = '0;
                        if (hdr_len == '0)
                        begin
                            frame_cnt_next = frame_cnt_reg + 1'b1;
                            plen_next      = '0;
                            kind           = sfr_pkg::EV_EMPTY_FRAME;
                        end
                        else
                        begin
                            phase_next = sfr_pkg::PH_PAYLOAD;
                            plen_next  = hdr_len;
                        end
                    end
                end
            end
            else
            begin
                pbyte      = item.rx_byte;
                kind       = sfr_pkg::EV_PAYLOAD_BYTE;
                pseen_next = seen_inc;
                if (seen_inc >= plen_reg)
                begin
                    last_flag      = 1'b1;
                    frame_cnt_next = frame_cnt_reg + 1'b1;
                    phase_next     = sfr_pkg::PH_HEADER;
                    hdr_pos_next   = 2'd0;
                    plen_next      = '0;
                    pseen_next     = '0;
                end
            end
        end
        else if (phase_reg == sfr_pkg::PH_PAYLOAD || hdr_pos_reg != 2'd0)
        begin
            if (idle_reg >= timeout_reg)
            begin
                // abort the partial frame
                idle_cnt_next = idle_cnt_reg + 1'b1;
                drop_cnt_next = drop_cnt_reg + STAT_WIDTH'(got);
                phase_next    = sfr_pkg::PH_HEADER;
                hdr_pos_next  = 2'd0;
                plen_next     = '0;
                pseen_next    = '0;
                idle_next     = '0;
                kind          = sfr_pkg::EV_IDLE_ABORT;
            end
            else if (idle_reg != sfr_pkg::IDLE_MAX)
            begin
                idle_next = idle_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sfr_pkg::PH_HEADER;
            hdr_pos_reg   <= 2'd0;
            plen_reg      <= '0;
            pseen_reg     <= '0;
            cur_ctr_reg   <= '0;
            cur_gap_reg   <= 1'b0;
            last_ctr_reg  <= '0;
            ctr_seen_reg  <= 1'b0;
            idle_reg      <= '0;
            fe_cnt_reg    <= '0;
            ctre_cnt_reg  <= '0;
            idle_cnt_reg  <= '0;
            drop_cnt_reg  <= '0;
            frame_cnt_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            hdr_pos_reg   <= hdr_pos_next;
            plen_reg      <= plen_next;
            pseen_reg     <= pseen_next;
            cur_ctr_reg   <= cur_ctr_next;
            cur_gap_reg   <= cur_gap_next;
            last_ctr_reg  <= last_ctr_next;
            ctr_seen_reg  <= ctr_seen_next;
            idle_reg      <= idle_next;
            fe_cnt_reg    <= fe_cnt_next;
            ctre_cnt_reg  <= ctre_cnt_next;
            idle_cnt_reg  <= idle_cnt_next;
            drop_cnt_reg  <= drop_cnt_next;
            frame_cnt_reg <= frame_cnt_next;
        end
    end

    // header bytes hold no reset value
    always_ff @(posedge clk)
    begin
        if (fire && item.func == sfr_pkg::FUNC_BYTE && phase_reg == sfr_pkg::PH_HEADER)
        begin
            case (hdr_pos_reg)
                2'd0:    hdr_b0_reg <= item.rx_byte;
                2'd1:    hdr_b1_reg <= item.rx_byte;
                2'd2:    hdr_b2_reg <= item.rx_byte;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        result.event_kind          = kind;
        result.payload_byte        = pbyte;
        result.frame_last          = last_flag;
        result.frame_ctr           = cur_ctr_next;
        result.ctr_gap             = cur_gap_next;
        result.framing_error_count = sfr_pkg::OUT_STAT_W'(64'(fe_cnt_next));
        result.ctr_error_count     = sfr_pkg::OUT_STAT_W'(64'(ctre_cnt_next));
        result.idle_timeout_count  = sfr_pkg::OUT_STAT_W'(64'(idle_cnt_next));
        result.dropped_byte_count  = sfr_pkg::OUT_STAT_W'(64'(drop_cnt_next));
        result.frame_count         = sfr_pkg::OUT_STAT_W'(64'(frame_cnt_next));
    end

    a_payload_no_hdr_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == sfr_pkg::PH_PAYLOAD |-> hdr_pos_reg == 2'd0)
        else $error("header position nonzero during payload");

    a_payload_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == sfr_pkg::PH_PAYLOAD |-> (plen_reg != '0 && pseen_reg < plen_reg))
        else $error("payload counter out of range");

    a_idle_only_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        idle_reg != '0 |-> (phase_reg == sfr_pkg::PH_PAYLOAD || hdr_pos_reg != 2'd0))
        else $error("idle timer running with no frame in flight");

    a_framing_counts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && kind == sfr_pkg::EV_FRAMING_ERROR |=> fe_cnt_reg == $past(fe_cnt_reg) + 1'b1)
        else $error("framing error not counted");

endmodule

[design/sfr_out_reg.sv]
// ----------------------------------------------------------------------------
// sfr_out_reg
// Result register toward the master stream; frees for a new result
// whenever it is empty or its result is being taken.
// ----------------------------------------------------------------------------
module sfr_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  sfr_pkg::result_t result,
    output logic             load_ok,
    output logic             m_valid,
    input  logic             m_ready,
    output sfr_pkg::result_t m_result
);

    logic             valid_reg;
    sfr_pkg::result_t result_reg;

    assign load_ok  = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

[design/sxi_frame_receiver.sv]
// ----------------------------------------------------------------------------
// sxi_frame_receiver
// Path from input accept to result valid: input register, then result
// register. Throughput: one item per cycle while m_axis_tready is high.
// Every item gives exactly one result; the deframer step is combinational.
// Reset (rst_n low, asynchronous) clears frame state, statistics and
// both stage valids and loads the register defaults (255, 50000).
// ----------------------------------------------------------------------------
module sxi_frame_receiver
#(
    parameter int STAT_WIDTH = sfr_pkg::STAT_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_addr,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // rx_byte
    input  logic                           s_axis_tuser,  // func
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // payload_byte, frame_ctr, ctr_gap, framing_error_count, ctr_error_count,
    // idle_timeout_count, dropped_byte_count, frame_count, zero fill
    output logic [191:0]                   m_axis_tdata,
    output logic [2:0]                     m_axis_tuser,  // event_kind
    output logic                           m_axis_tlast   // frame_last
);

    sfr_pkg::in_item_t s_item;
    sfr_pkg::in_item_t item;
    sfr_pkg::result_t  result;
    sfr_pkg::result_t  m_result;
    logic              item_valid;
    logic              load_ok;
    logic              fire;

    assign s_item.func    = s_axis_tuser;
    assign s_item.rx_byte = s_axis_tdata;
    assign fire           = item_valid && load_ok;

    sfr_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .advance    (load_ok),
        .item_valid (item_valid),
        .item       (item)
    );

    sfr_deframer #(
        .STAT_WIDTH (STAT_WIDTH)
    ) u_deframer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (item),
        .result    (result)
    );

    sfr_out_reg u_out_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .result   (result),
        .load_ok  (load_ok),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_result (m_result)
    );

    assign m_axis_tuser = m_result.event_kind;
    assign m_axis_tlast = m_result.frame_last;
    assign m_axis_tdata = {7'd0,
                           m_result.frame_count,
                           m_result.dropped_byte_count,
                           m_result.idle_timeout_count,
                           m_result.ctr_error_count,
                           m_result.framing_error_count,
                           m_result.ctr_gap,
                           m_result.frame_ctr,
                           m_result.payload_byte};

endmodule
